@@ hdl/lpht_pkg.sv @@
// lpht_pkg: shared types, codes and sizes for the linear probing hash table
// used by lpht_ctrl, lpht_dp and linear_probe_hash_table_core, no dependencies
package lpht_pkg;

  localparam int SLOT_COUNT = 11;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int REM_W      = SLOT_W + 1;

  localparam int KEY_W      = 63;
  localparam int WORD_W     = 64;
  localparam int NAME_W     = 4 * WORD_W;

  // key is reduced modulo SLOT_COUNT one byte per cycle
  localparam int CHUNK_W    = 8;
  localparam int CHUNKS     = (KEY_W + CHUNK_W - 1) / CHUNK_W;
  localparam int SHIFT_W    = CHUNKS * CHUNK_W;
  localparam int CHUNK_CW   = $clog2(CHUNKS);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_FULL    = 2'd1;
  localparam logic [1:0] RC_MISSING = 2'd2;
  localparam logic [1:0] RC_INVALID = 2'd3;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_st_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] name_word0;
    logic [WORD_W-1:0] name_word1;
    logic [WORD_W-1:0] name_word2;
    logic [WORD_W-1:0] name_word3;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] found_word0;
    logic [WORD_W-1:0] found_word1;
    logic [WORD_W-1:0] found_word2;
    logic [WORD_W-1:0] found_word3;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       reduce;
    logic       probe_step;
    logic       ins_write;
    logic       mark_del;
    logic       name_rd;
    logic       finish;
    logic       use_name;
    logic [1:0] rc;
  } cmd_t;

  typedef struct packed {
    logic       bad;
    logic       reduce_last;
    logic       slot_free;
    logic       slot_empty;
    logic       key_match;
    logic       probe_last;
    logic [1:0] opcode;
  } sts_t;

endpackage

@@ hdl/lpht_ctrl.sv @@
// lpht_ctrl: operation sequencer for the hash table (reduce, probe, read, answer)
// depends on lpht_pkg, drives lpht_dp through cmd_t and reads back sts_t
module lpht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lpht_pkg::sts_t sts_i,
  output lpht_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_PROBE,
    S_READ
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts_i.bad) begin
          cmd_o.finish = 1'b1;
          cmd_o.rc     = lpht_pkg::RC_INVALID;
          state_d      = S_IDLE;
        end else begin
          cmd_o.reduce = 1'b1;
          if (sts_i.reduce_last) state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.opcode == lpht_pkg::OP_INSERT) begin
          if (sts_i.slot_free) begin
            cmd_o.ins_write = 1'b1;
            cmd_o.finish    = 1'b1;
            cmd_o.rc        = lpht_pkg::RC_OK;
            state_d         = S_IDLE;
          end else if (sts_i.probe_last) begin
            cmd_o.finish = 1'b1;
            cmd_o.rc     = lpht_pkg::RC_FULL;
            state_d      = S_IDLE;
          end else begin
            cmd_o.probe_step = 1'b1;
          end
        end else begin
          if (sts_i.slot_empty) begin
            cmd_o.finish = 1'b1;
            cmd_o.rc     = lpht_pkg::RC_MISSING;
            state_d      = S_IDLE;
          end else if (sts_i.key_match) begin
            if (sts_i.opcode == lpht_pkg::OP_SEARCH) begin
              cmd_o.name_rd = 1'b1;
              state_d       = S_READ;
            end else begin
              cmd_o.mark_del = 1'b1;
              cmd_o.finish   = 1'b1;
              cmd_o.rc       = lpht_pkg::RC_OK;
              state_d        = S_IDLE;
            end
          end else if (sts_i.probe_last) begin
            cmd_o.finish = 1'b1;
            cmd_o.rc     = lpht_pkg::RC_MISSING;
            state_d      = S_IDLE;
          end else begin
            cmd_o.probe_step = 1'b1;
          end
        end
      end
      S_READ: begin
        // name row read was issued last cycle and is registered now
        cmd_o.finish   = 1'b1;
        cmd_o.use_name = 1'b1;
        cmd_o.rc       = lpht_pkg::RC_OK;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  a_finish_returns_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == S_IDLE))
    else $error("answer given but sequencer did not return to idle");

  a_no_step_past_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.probe_step |-> !sts_i.probe_last)
    else $error("probe advanced past the last slot");

  a_single_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ins_write && cmd_o.mark_del))
    else $error("insert and delete update in the same cycle");

  a_read_then_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.name_rd |=> (cmd_o.finish && cmd_o.use_name))
    else $error("name read not followed by a search answer");

endmodule

@@ hdl/lpht_dp.sv @@
// lpht_dp: hash table datapath: key modulo unit, probe pointer, slot status and
// key arrays, name memory and result register; depends on lpht_pkg
module lpht_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lpht_pkg::in_t  in_i,
  input  lpht_pkg::cmd_t cmd_i,
  output lpht_pkg::sts_t sts_o,
  output logic           valid_o,
  output lpht_pkg::out_t res_o
);

  lpht_pkg::in_t                      in_q;
  logic [lpht_pkg::SHIFT_W-1:0]       sh_q;
  logic [lpht_pkg::REM_W-1:0]         r_q, r_d;
  logic [lpht_pkg::CHUNK_CW-1:0]      chunk_q;
  logic [lpht_pkg::SLOT_W-1:0]        ptr_q, ptr_nxt;
  logic [lpht_pkg::SLOT_W-1:0]        cnt_q;
  lpht_pkg::slot_st_e                 slot_st_q  [lpht_pkg::SLOT_COUNT];
  logic [lpht_pkg::KEY_W-1:0]         slot_key_q [lpht_pkg::SLOT_COUNT];
  logic [lpht_pkg::NAME_W-1:0]        name_mem   [lpht_pkg::SLOT_COUNT];
  logic [lpht_pkg::NAME_W-1:0]        name_rd_q;
  lpht_pkg::out_t                     res_q;
  logic                               valid_q;
  lpht_pkg::slot_st_e                 cur_st;
  logic                               op_ok;

  // restoring remainder, one key bit per step, one byte per cycle
  always_comb begin
    r_d = r_q;
    for (int b = 0; b < lpht_pkg::CHUNK_W; b++) begin
      r_d = {r_d[lpht_pkg::REM_W-2:0], sh_q[lpht_pkg::SHIFT_W-1-b]};
      if (r_d >= lpht_pkg::REM_W'(lpht_pkg::SLOT_COUNT)) begin
        r_d = r_d - lpht_pkg::REM_W'(lpht_pkg::SLOT_COUNT);
      end
    end
  end

  assign ptr_nxt = (ptr_q == lpht_pkg::SLOT_W'(lpht_pkg::SLOT_COUNT - 1)) ?
                   '0 : ptr_q + lpht_pkg::SLOT_W'(1);
  assign cur_st  = slot_st_q[ptr_q];
  assign op_ok   = (in_q.opcode == lpht_pkg::OP_INSERT) ||
                   (in_q.opcode == lpht_pkg::OP_SEARCH) ||
                   (in_q.opcode == lpht_pkg::OP_DELETE);

  always_comb begin
    sts_o.bad         = (in_q.key == '0) || !op_ok;
    sts_o.reduce_last = (chunk_q == lpht_pkg::CHUNK_CW'(lpht_pkg::CHUNKS - 1));
    sts_o.slot_free   = (cur_st != lpht_pkg::SLOT_USED);
    sts_o.slot_empty  = (cur_st == lpht_pkg::SLOT_EMPTY);
    sts_o.key_match   = (cur_st == lpht_pkg::SLOT_USED) && (slot_key_q[ptr_q] == in_q.key);
    sts_o.probe_last  = (cnt_q == lpht_pkg::SLOT_W'(lpht_pkg::SLOT_COUNT - 1));
    sts_o.opcode      = in_q.opcode;
  end

  // operand and probe registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q    <= in_i;
      sh_q    <= lpht_pkg::SHIFT_W'(in_i.key);
      r_q     <= '0;
      chunk_q <= '0;
    end else if (cmd_i.reduce) begin
      sh_q    <= {sh_q[lpht_pkg::SHIFT_W-lpht_pkg::CHUNK_W-1:0], lpht_pkg::CHUNK_W'(0)};
      r_q     <= r_d;
      chunk_q <= chunk_q + lpht_pkg::CHUNK_CW'(1);
      if (sts_o.reduce_last) begin
        ptr_q <= r_d[lpht_pkg::SLOT_W-1:0];
        cnt_q <= '0;
      end
    end else if (cmd_i.probe_step) begin
      ptr_q <= ptr_nxt;
      cnt_q <= cnt_q + lpht_pkg::SLOT_W'(1);
    end
  end

  // slot status resets to empty, keys only matter behind a used status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lpht_pkg::SLOT_COUNT; i++) begin
        slot_st_q[i] <= lpht_pkg::SLOT_EMPTY;
      end
    end else if (cmd_i.ins_write) begin
      slot_st_q[ptr_q] <= lpht_pkg::SLOT_USED;
    end else if (cmd_i.mark_del) begin
      slot_st_q[ptr_q] <= lpht_pkg::SLOT_DELETED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_write) begin
      slot_key_q[ptr_q] <= in_q.key;
    end
  end

  // name memory, one 256-bit row per slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_write) begin
      name_mem[ptr_q] <= {in_q.name_word3, in_q.name_word2,
                          in_q.name_word1, in_q.name_word0};
    end
    if (cmd_i.name_rd) begin
      name_rd_q <= name_mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.status <= cmd_i.rc;
      if (cmd_i.use_name) begin
        res_q.found_word0 <= name_rd_q[0*lpht_pkg::WORD_W +: lpht_pkg::WORD_W];
        res_q.found_word1 <= name_rd_q[1*lpht_pkg::WORD_W +: lpht_pkg::WORD_W];
        res_q.found_word2 <= name_rd_q[2*lpht_pkg::WORD_W +: lpht_pkg::WORD_W];
        res_q.found_word3 <= name_rd_q[3*lpht_pkg::WORD_W +: lpht_pkg::WORD_W];
      end else begin
        res_q.found_word0 <= '0;
        res_q.found_word1 <= '0;
        res_q.found_word2 <= '0;
        res_q.found_word3 <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hdl/linear_probe_hash_table_core.sv @@
// linear_probe_hash_table_core: 11-slot open addressing table, linear probing.
// a zero key or unused opcode is answered as invalid without probing; else the
// key is reduced modulo one byte per cycle, then up to 11 slots are probed,
// and a search hit adds a name row read before the result.
// one operation at a time; busy drops in the cycle the result strobe shows.
// reset empties every slot at once; results cannot be stalled by the receiver.
module linear_probe_hash_table_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lpht_pkg::in_t  in_i,
  output logic           valid_o,
  output lpht_pkg::out_t res_o
);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lpht_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule
